/* rtl/sap_pkg.sv */
`default_nettype none
// ============================================================================
// sap_pkg - shared types, constants and microprogram
// Widths, register codes and the control store of the allpass ambience core.
// ============================================================================
package sap_pkg;

    localparam int LINE_DEPTH_DEF   = 1024;
    localparam int SAMPLE_WIDTH_DEF = 24;

    localparam int FIELD_W   = 24;
    localparam int INNER_W   = 28;
    localparam int DAMP_W    = 15;
    localparam int DRY_W     = 16;
    localparam int WET_W     = 15;
    localparam int DELAY_W   = 10;
    localparam int CFG_W     = 16;
    localparam int REG_IDX_W = 3;
    localparam int COEF_W    = 17;
    localparam int MDATA_W   = 30;
    localparam int PROD_W    = 47;
    localparam int RND_SHIFT = 15;
    localparam int ALU_W     = 32;
    localparam int E_W       = 30;
    localparam int LINES     = 4;

    localparam logic [DRY_W-1:0]          FB_Q15     = 16'd26214;
    localparam logic signed [PROD_W-1:0]  ROUND_HALF = 47'sd16384;

    // register indexes
    localparam logic [REG_IDX_W-1:0] REG_DAMP        = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_DRY         = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_WET         = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_ONE   = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_TWO   = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_THREE = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_DELAY_FOUR  = 3'd6;

    localparam logic [DAMP_W-1:0]  DAMP_RST        = 15'd16384;
    localparam logic [DRY_W-1:0]   DRY_RST         = 16'd32768;
    localparam logic [WET_W-1:0]   WET_RST         = 15'd0;
    localparam logic [DELAY_W-1:0] DELAY_ONE_RST   = 10'd2;
    localparam logic [DELAY_W-1:0] DELAY_TWO_RST   = 10'd3;
    localparam logic [DELAY_W-1:0] DELAY_THREE_RST = 10'd6;
    localparam logic [DELAY_W-1:0] DELAY_FOUR_RST  = 10'd9;

    // sequencer conditions
    localparam logic [1:0] COND_NONE  = 2'd0;
    localparam logic [1:0] COND_START = 2'd1;
    localparam logic [1:0] COND_OUT   = 2'd2;
    localparam logic [1:0] COND_CLEAR = 2'd3;

    // multiplier coefficient / data selects
    localparam logic [1:0] MC_WET  = 2'd0;
    localparam logic [1:0] MC_DAMP = 2'd1;
    localparam logic [1:0] MC_FB   = 2'd2;
    localparam logic [1:0] MC_DRY  = 2'd3;
    localparam logic [1:0] MD_E    = 2'd0;
    localparam logic [1:0] MD_T    = 2'd1;
    localparam logic [1:0] MD_A    = 2'd2;
    localparam logic [1:0] MD_B    = 2'd3;

    // adder operands
    localparam logic [2:0] OP_ZERO = 3'd0;
    localparam logic [2:0] OP_P    = 3'd1;
    localparam logic [2:0] OP_R    = 3'd2;
    localparam logic [2:0] OP_F    = 3'd3;
    localparam logic [2:0] OP_E    = 3'd4;
    localparam logic [2:0] OP_A    = 3'd5;
    localparam logic [2:0] OP_B    = 3'd6;
    localparam logic [2:0] OP_T    = 3'd7;

    localparam logic [1:0] SAT_NONE   = 2'd0;
    localparam logic [1:0] SAT_INNER  = 2'd1;
    localparam logic [1:0] SAT_SAMPLE = 2'd2;

    localparam logic [2:0] DST_NONE = 3'd0;
    localparam logic [2:0] DST_E    = 3'd1;
    localparam logic [2:0] DST_R    = 3'd2;
    localparam logic [2:0] DST_FR   = 3'd3;
    localparam logic [2:0] DST_LO   = 3'd4;
    localparam logic [2:0] DST_RO   = 3'd5;

    localparam logic [1:0] LN_ONE   = 2'd0;
    localparam logic [1:0] LN_TWO   = 2'd1;
    localparam logic [1:0] LN_THREE = 2'd2;
    localparam logic [1:0] LN_FOUR  = 2'd3;

    localparam int STEP_W = 5;
    localparam logic [STEP_W-1:0] STEP_IDLE  = 5'd0;
    localparam logic [STEP_W-1:0] STEP_LAST  = 5'd17;
    localparam logic [STEP_W-1:0] STEP_CLEAR = 5'd18;

    typedef struct packed {
        logic       en;
        logic [1:0] coef;
        logic [1:0] data;
        logic [1:0] line;
    } mul_ctl_t;

    typedef struct packed {
        logic [2:0] x;
        logic [2:0] y;
        logic       sub;
        logic [1:0] sat;
        logic [2:0] dst;
        logic [1:0] line;
        logic       we;
    } alu_ctl_t;

    typedef struct packed {
        logic [1:0]        cond;
        logic [STEP_W-1:0] jump;
        logic              clear;
        mul_ctl_t          mul;
        alu_ctl_t          alu;
    } ucode_t;

    localparam mul_ctl_t MUL_NOP = '{1'b0, MC_WET, MD_E, LN_ONE};
    localparam alu_ctl_t ALU_NOP = '{OP_ZERO, OP_ZERO, 1'b0, SAT_NONE, DST_NONE, LN_ONE, 1'b0};

    // control store: one word per step
    function automatic ucode_t sap_ucode(input logic [STEP_W-1:0] step);
        ucode_t w;
        w.cond  = COND_NONE;
        w.jump  = STEP_IDLE;
        w.clear = 1'b0;
        w.mul   = MUL_NOP;
        w.alu   = ALU_NOP;
        unique case (step)
            STEP_IDLE: w.cond = COND_START;
            5'd1:  w.alu = '{OP_A, OP_B, 1'b0, SAT_NONE, DST_E, LN_ONE, 1'b0};
            5'd2:  w.mul = '{1'b1, MC_WET, MD_E, LN_ONE};
            5'd3:  w.alu = '{OP_P, OP_F, 1'b1, SAT_INNER, DST_E, LN_ONE, 1'b0};
            5'd4:  w.mul = '{1'b1, MC_DAMP, MD_E, LN_ONE};
            5'd5: begin
                w.alu = '{OP_F, OP_P, 1'b0, SAT_INNER, DST_FR, LN_ONE, 1'b0};
                w.mul = '{1'b1, MC_FB, MD_T, LN_ONE};
            end
            5'd6:  w.alu = '{OP_R, OP_P, 1'b1, SAT_INNER, DST_R, LN_ONE, 1'b1};
            5'd7: begin
                w.alu = '{OP_R, OP_T, 1'b0, SAT_INNER, DST_R, LN_ONE, 1'b0};
                w.mul = '{1'b1, MC_FB, MD_T, LN_TWO};
            end
            5'd8:  w.alu = '{OP_R, OP_P, 1'b1, SAT_INNER, DST_R, LN_TWO, 1'b1};
            5'd9: begin
                w.alu = '{OP_R, OP_T, 1'b0, SAT_INNER, DST_R, LN_TWO, 1'b0};
                w.mul = '{1'b1, MC_FB, MD_T, LN_THREE};
            end
            5'd10: w.alu = '{OP_R, OP_P, 1'b1, SAT_INNER, DST_R, LN_THREE, 1'b1};
            5'd11: begin
                w.alu = '{OP_R, OP_T, 1'b0, SAT_INNER, DST_R, LN_THREE, 1'b0};
                w.mul = '{1'b1, MC_DRY, MD_A, LN_ONE};
            end
            5'd12: w.alu = '{OP_R, OP_F, 1'b1, SAT_NONE, DST_E, LN_ONE, 1'b0};
            5'd13: begin
                w.alu = '{OP_P, OP_E, 1'b0, SAT_SAMPLE, DST_LO, LN_ONE, 1'b0};
                w.mul = '{1'b1, MC_FB, MD_T, LN_FOUR};
            end
            5'd14: begin
                w.alu = '{OP_R, OP_P, 1'b1, SAT_INNER, DST_R, LN_FOUR, 1'b1};
                w.mul = '{1'b1, MC_DRY, MD_B, LN_ONE};
            end
            5'd15: w.alu = '{OP_R, OP_T, 1'b0, SAT_INNER, DST_R, LN_FOUR, 1'b0};
            5'd16: w.alu = '{OP_R, OP_F, 1'b1, SAT_NONE, DST_E, LN_ONE, 1'b0};
            STEP_LAST: begin
                w.cond = COND_OUT;
                w.jump = STEP_IDLE;
                w.alu  = '{OP_P, OP_E, 1'b0, SAT_SAMPLE, DST_RO, LN_ONE, 1'b0};
            end
            STEP_CLEAR: begin
                w.cond  = COND_CLEAR;
                w.jump  = STEP_IDLE;
                w.clear = 1'b1;
            end
            default: w.cond = COND_NONE;
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

/* rtl/stereo_allpass_ambience_core.sv */
`default_nettype none
// ============================================================================
// stereo_allpass_ambience_core - allpass ambience reverb, top level
// Microcoded sequencer, config registers and stream handshake.
// ============================================================================
//  channel  | dir | ports                         | content
//  ---------+-----+-------------------------------+-------------------------------
//  s_       | in  | s_tvalid s_tready s_tdata[47:0] | left_in, right_in
//  m_       | out | m_tvalid m_tready m_tdata[47:0] | left_out, right_out
//  cfg_     | in  | cfg_we cfg_index cfg_data       | register write, no read-back
//
//  One request runs from acceptance to the next s_tready through a 17-step
//  microprogram sharing one multiplier and one saturating adder, plus the idle step.
//  After reset and after any delay register write, a clearing pass zeroes the
//  four lines; s_tready is low during it.
//  The last step waits while the output register holds an untaken result.
// ============================================================================
module stereo_allpass_ambience_core
    import sap_pkg::*;
#(
    parameter int LINE_DEPTH   = LINE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [2*FIELD_W-1:0] s_tdata,   // left_in, right_in
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [2*FIELD_W-1:0] m_tdata,   // left_out, right_out
    input  wire logic                 cfg_we,
    input  wire logic [REG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data
);

    localparam int AW        = $clog2(LINE_DEPTH);
    localparam int RW        = ((AW > DELAY_W) ? AW : DELAY_W) + 1;
    localparam int RED_STEPS = ((1 << DELAY_W) - 1) / LINE_DEPTH;

    function automatic logic [AW-1:0] reduce_delay(input logic [DELAY_W-1:0] d);
        logic [RW-1:0] v;
        v = RW'(d);
        for (int k = 0; k < RED_STEPS; k++) begin
            if (v >= RW'(LINE_DEPTH)) begin
                v = v - RW'(LINE_DEPTH);
            end
        end
        return v[AW-1:0];
    endfunction

    logic [DAMP_W-1:0]          damp_reg;
    logic [DRY_W-1:0]           dry_reg;
    logic [WET_W-1:0]           wet_reg;
    logic [LINES-1:0][AW-1:0]   dmod_reg;
    logic [AW-1:0]              rp_reg, rp_next;
    logic [AW-1:0]              clr_cnt_reg;
    logic                       clear_pending_reg;
    logic [STEP_W-1:0]          step_reg, step_next;
    logic                       m_tvalid_reg;

    ucode_t                     uc;
    logic                       go, s_accept, out_load, delay_wr, clr_last;
    logic [LINES-1:0][AW-1:0]   wr_addr;
    logic [AW:0]                wsum;

    assign delay_wr = cfg_we && (cfg_index == REG_DELAY_ONE || cfg_index == REG_DELAY_TWO ||
                                 cfg_index == REG_DELAY_THREE || cfg_index == REG_DELAY_FOUR);
    assign clr_last = (clr_cnt_reg == AW'(LINE_DEPTH - 1));
    assign rp_next  = (rp_reg == AW'(LINE_DEPTH - 1)) ? '0 : rp_reg + 1'b1;

    always_comb begin
        uc        = sap_ucode(step_reg);
        go        = 1'b0;
        step_next = step_reg;
        unique case (uc.cond)
            COND_NONE: begin
                go        = 1'b1;
                step_next = step_reg + 1'b1;
            end
            COND_START: begin
                if (clear_pending_reg) begin
                    step_next = STEP_CLEAR;
                end else if (s_tvalid) begin
                    step_next = step_reg + 1'b1;
                end
            end
            COND_OUT: begin
                go = !m_tvalid_reg || m_tready;
                if (go) begin
                    step_next = uc.jump;
                end
            end
            COND_CLEAR: begin
                go = 1'b1;
                if (clr_last && !delay_wr) begin
                    step_next = uc.jump;
                end
            end
        endcase
    end

    assign s_tready = (uc.cond == COND_START) && !clear_pending_reg;
    assign s_accept = s_tvalid && s_tready;
    assign out_load = go && (uc.alu.dst == DST_RO);

    always_comb begin
        wsum = '0;
        for (int i = 0; i < LINES; i++) begin
            wsum = {1'b0, rp_reg} + {1'b0, dmod_reg[i]};
            if (wsum >= (AW + 1)'(LINE_DEPTH)) begin
                wsum = wsum - (AW + 1)'(LINE_DEPTH);
            end
            wr_addr[i] = wsum[AW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            damp_reg         <= DAMP_RST;
            dry_reg          <= DRY_RST;
            wet_reg          <= WET_RST;
            dmod_reg[LN_ONE]   <= reduce_delay(DELAY_ONE_RST);
            dmod_reg[LN_TWO]   <= reduce_delay(DELAY_TWO_RST);
            dmod_reg[LN_THREE] <= reduce_delay(DELAY_THREE_RST);
            dmod_reg[LN_FOUR]  <= reduce_delay(DELAY_FOUR_RST);
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_DAMP:        damp_reg <= cfg_data[DAMP_W-1:0];
                REG_DRY:         dry_reg  <= cfg_data[DRY_W-1:0];
                REG_WET:         wet_reg  <= cfg_data[WET_W-1:0];
                REG_DELAY_ONE:   dmod_reg[LN_ONE]   <= reduce_delay(cfg_data[DELAY_W-1:0]);
                REG_DELAY_TWO:   dmod_reg[LN_TWO]   <= reduce_delay(cfg_data[DELAY_W-1:0]);
                REG_DELAY_THREE: dmod_reg[LN_THREE] <= reduce_delay(cfg_data[DELAY_W-1:0]);
                REG_DELAY_FOUR:  dmod_reg[LN_FOUR]  <= reduce_delay(cfg_data[DELAY_W-1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg          <= STEP_IDLE;
            rp_reg            <= '0;
            clr_cnt_reg       <= '0;
            clear_pending_reg <= 1'b1;
            m_tvalid_reg      <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (out_load) begin
                rp_reg <= rp_next;
            end
            if (delay_wr) begin
                clr_cnt_reg       <= '0;
                clear_pending_reg <= 1'b1;
            end else if (uc.clear) begin
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
                if (clr_last) begin
                    clear_pending_reg <= 1'b0;
                end
            end
            if (out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    sap_datapath #(
        .LINE_DEPTH   (LINE_DEPTH),
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_datapath (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .uc         (uc),
        .go         (go),
        .load_in    (s_accept),
        .in_left    (s_tdata[FIELD_W-1:0]),
        .in_right   (s_tdata[2*FIELD_W-1:FIELD_W]),
        .rd_addr    (rp_reg),
        .wr_addr    (wr_addr),
        .clr_en     (uc.clear),
        .clr_addr   (clr_cnt_reg),
        .damp_coeff (damp_reg),
        .dry_gain   (dry_reg),
        .wet_gain   (wet_reg),
        .out_left   (m_tdata[FIELD_W-1:0]),
        .out_right  (m_tdata[2*FIELD_W-1:FIELD_W])
    );

    assign m_tvalid = m_tvalid_reg;

endmodule
`default_nettype wire

/* rtl/sap_ram.sv */
`default_nettype none
// ============================================================================
// sap_ram - generic simple dual-port RAM
// One write port, one read port with registered read data.
// ============================================================================
module sap_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

/* rtl/sap_datapath.sv */
`default_nettype none
// ============================================================================
// sap_datapath - multiplier, saturating adder and delay lines
// Executes one control word per step: at most one Q1.15 multiply and one add/sub.
// ============================================================================
module sap_datapath
    import sap_pkg::*;
#(
    parameter int LINE_DEPTH   = LINE_DEPTH_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF,
    localparam int AW = $clog2(LINE_DEPTH)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire ucode_t                        uc,
    input  wire logic                          go,
    input  wire logic                          load_in,
    input  wire logic signed [FIELD_W-1:0]     in_left,
    input  wire logic signed [FIELD_W-1:0]     in_right,
    input  wire logic [AW-1:0]                 rd_addr,
    input  wire logic [LINES-1:0][AW-1:0]      wr_addr,
    input  wire logic                          clr_en,
    input  wire logic [AW-1:0]                 clr_addr,
    input  wire logic [DAMP_W-1:0]             damp_coeff,
    input  wire logic [DRY_W-1:0]              dry_gain,
    input  wire logic [WET_W-1:0]              wet_gain,
    output logic [FIELD_W-1:0]                 out_left,
    output logic [FIELD_W-1:0]                 out_right
);

    localparam logic signed [ALU_W-1:0] INNER_MAX =
        ALU_W'((64'sd1 <<< (INNER_W - 1)) - 64'sd1);
    localparam logic signed [ALU_W-1:0] INNER_MIN = ALU_W'(-(64'sd1 <<< (INNER_W - 1)));
    localparam logic signed [ALU_W-1:0] SAMPLE_MAX =
        ALU_W'((64'sd1 <<< (SAMPLE_WIDTH - 1)) - 64'sd1);
    localparam logic signed [ALU_W-1:0] SAMPLE_MIN =
        ALU_W'(-(64'sd1 <<< (SAMPLE_WIDTH - 1)));

    logic signed [FIELD_W-1:0] a_reg, b_reg;
    logic signed [INNER_W-1:0] r_reg, f_reg;
    logic signed [E_W-1:0]     e_reg;
    logic [FIELD_W-1:0]        lo_reg, out_left_reg, out_right_reg;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;

    logic [LINES-1:0][INNER_W-1:0] rdata;
    logic [LINES-1:0]              line_we;
    logic [LINES-1:0][AW-1:0]      line_waddr;
    logic [INNER_W-1:0]            line_wdata;

    logic signed [COEF_W-1:0]  mc;
    logic signed [MDATA_W-1:0] md;
    logic signed [ALU_W-1:0]   ops [8];
    logic signed [ALU_W-1:0]   xv, yv, sum, res;

    // multiplier with rounding offset folded in
    always_comb begin
        unique case (uc.mul.coef)
            MC_WET:  mc = $signed({2'b00, wet_gain});
            MC_DAMP: mc = $signed({2'b00, damp_coeff});
            MC_FB:   mc = $signed({1'b0, FB_Q15});
            MC_DRY:  mc = $signed({1'b0, dry_gain});
        endcase
        unique case (uc.mul.data)
            MD_E: md = MDATA_W'(e_reg);
            MD_T: md = MDATA_W'($signed(rdata[uc.mul.line]));
            MD_A: md = MDATA_W'(a_reg);
            MD_B: md = MDATA_W'(b_reg);
        endcase
        prod_next = mc * md + ROUND_HALF;
    end

    // adder with selectable saturation
    always_comb begin
        ops[OP_ZERO] = '0;
        ops[OP_P]    = prod_reg[PROD_W-1:RND_SHIFT];
        ops[OP_R]    = ALU_W'(r_reg);
        ops[OP_F]    = ALU_W'(f_reg);
        ops[OP_E]    = ALU_W'(e_reg);
        ops[OP_A]    = ALU_W'(a_reg);
        ops[OP_B]    = ALU_W'(b_reg);
        ops[OP_T]    = ALU_W'($signed(rdata[uc.alu.line]));
        xv  = ops[uc.alu.x];
        yv  = ops[uc.alu.y];
        sum = uc.alu.sub ? xv - yv : xv + yv;
        unique case (uc.alu.sat)
            SAT_INNER: begin
                if (sum > INNER_MAX) begin
                    res = INNER_MAX;
                end else if (sum < INNER_MIN) begin
                    res = INNER_MIN;
                end else begin
                    res = sum;
                end
            end
            SAT_SAMPLE: begin
                if (sum > SAMPLE_MAX) begin
                    res = SAMPLE_MAX;
                end else if (sum < SAMPLE_MIN) begin
                    res = SAMPLE_MIN;
                end else begin
                    res = sum;
                end
            end
            default: res = sum;
        endcase
    end

    assign line_wdata = clr_en ? '0 : res[INNER_W-1:0];

    for (genvar i = 0; i < LINES; i++) begin : g_line
        assign line_we[i]    = clr_en || (go && uc.alu.we && uc.alu.line == 2'(i));
        assign line_waddr[i] = clr_en ? clr_addr : wr_addr[i];

        sap_ram #(
            .WIDTH (INNER_W),
            .DEPTH (LINE_DEPTH)
        ) u_line (
            .clk   (aclk),
            .we    (line_we[i]),
            .waddr (line_waddr[i]),
            .wdata (line_wdata),
            .re    (load_in),
            .raddr (rd_addr),
            .rdata (rdata[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (load_in) begin
            a_reg <= in_left;
            b_reg <= in_right;
        end
        if (go && uc.mul.en) begin
            prod_reg <= prod_next;
        end
        if (go) begin
            unique case (uc.alu.dst)
                DST_E:  e_reg <= res[E_W-1:0];
                DST_R:  r_reg <= res[INNER_W-1:0];
                DST_FR: r_reg <= res[INNER_W-1:0];
                DST_LO: lo_reg <= res[FIELD_W-1:0];
                DST_RO: begin
                    out_right_reg <= res[FIELD_W-1:0];
                    out_left_reg  <= lo_reg;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_reg <= '0;
        end else if (go && uc.alu.dst == DST_FR) begin
            f_reg <= res[INNER_W-1:0];
        end
    end

    assign out_left  = out_left_reg;
    assign out_right = out_right_reg;

endmodule
`default_nettype wire

/* rtl/sap_checker.sv */
`default_nettype none
// ============================================================================
// sap_checker - port-level checks for the allpass ambience core
// Handshake, single request in flight, latency and clear-pass behavior.
// ============================================================================
module sap_checker
    import sap_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [2*FIELD_W-1:0] m_tdata,
    input wire logic                 cfg_we,
    input wire logic [REG_IDX_W-1:0] cfg_index
);

    localparam int LAT = int'(STEP_LAST) + 1;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second request taken while busy");

    a_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, LAT))
        else $error("result without matching request");

    a_clear_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we && (cfg_index == REG_DELAY_ONE || cfg_index == REG_DELAY_TWO ||
                   cfg_index == REG_DELAY_THREE || cfg_index == REG_DELAY_FOUR)
        |=> !s_tready)
        else $error("input ready during line clear");

endmodule

bind stereo_allpass_ambience_core sap_checker u_sap_checker (.*);
`default_nettype wire
